>>> src/assert_macros.svh
// Assertion macros shared by the mouse report accumulator RTL.
// Each macro checks on the rising clock edge and is disabled while reset is low.
// The checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> src/hmra_pkg.sv
// Types and constants for the HID mouse report accumulator.
// No dependencies; imported by the core, the output buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hmra_pkg;

    // Action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_MOVE   = 2'd0,
        ACT_WHEEL  = 2'd1,
        ACT_BUTTON = 2'd2,
        ACT_POLL   = 2'd3
    } t_action;

    localparam int unsigned XY_W     = 16;
    localparam int unsigned WHEEL_W  = 8;
    localparam int unsigned BTN_W    = 5;
    localparam int unsigned BTN_IDX_W = 3;

    localparam logic [BTN_IDX_W-1:0] BTN_LAST = 3'd4;

    localparam logic signed [XY_W-1:0]    XY_MAX    = 16'sd32767;
    localparam logic signed [XY_W-1:0]    XY_MIN    = -16'sd32767;
    localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = 8'sd127;
    localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = -8'sd127;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned IN_TUSER_W  = 2;

    // One input action, minus its action code
    typedef struct packed {
        logic                    pressed;
        logic [BTN_IDX_W-1:0]    button_index;
        logic signed [WHEEL_W-1:0] wheel_step;
        logic signed [XY_W-1:0]  step_y;
        logic signed [XY_W-1:0]  step_x;
    } t_action_in;

    // One report
    typedef struct packed {
        logic signed [WHEEL_W-1:0] sum_wheel;
        logic signed [XY_W-1:0]  sum_y;
        logic signed [XY_W-1:0]  sum_x;
        logic [BTN_W-1:0]        button_bits;
    } t_report;

endpackage

`default_nettype wire

>>> src/hmra_core.sv
// Accumulator state and report decision for the HID mouse report accumulator.
// Depends on hmra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hmra_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  hmra_pkg::t_action        i_action,
    input  hmra_pkg::t_action_in     i_item,
    output logic                     o_rpt_valid,
    output hmra_pkg::t_report        o_rpt
);
    import hmra_pkg::*;

    logic [BTN_W-1:0]          r_buttons_now, n_buttons_now;
    logic [BTN_W-1:0]          r_buttons_sent, n_buttons_sent;
    logic signed [XY_W-1:0]    r_acc_x, n_acc_x;
    logic signed [XY_W-1:0]    r_acc_y, n_acc_y;
    logic signed [WHEEL_W-1:0] r_acc_wheel, n_acc_wheel;
    logic                      w_pending;

    // Add a step to an X/Y sum and clamp to the symmetric range
    function automatic logic signed [XY_W-1:0] sat_xy(
        input logic signed [XY_W-1:0] acc,
        input logic signed [XY_W-1:0] step
    );
        logic signed [XY_W:0] sum;
        sum = $signed({acc[XY_W-1], acc}) + $signed({step[XY_W-1], step});
        if (sum > $signed({XY_MAX[XY_W-1], XY_MAX})) begin
            return XY_MAX;
        end else if (sum < $signed({XY_MIN[XY_W-1], XY_MIN})) begin
            return XY_MIN;
        end
        return sum[XY_W-1:0];
    endfunction

    // Add a step to the wheel sum and clamp
    function automatic logic signed [WHEEL_W-1:0] sat_wheel(
        input logic signed [WHEEL_W-1:0] acc,
        input logic signed [WHEEL_W-1:0] step
    );
        logic signed [WHEEL_W:0] sum;
        sum = $signed({acc[WHEEL_W-1], acc}) + $signed({step[WHEEL_W-1], step});
        if (sum > $signed({WHEEL_MAX[WHEEL_W-1], WHEEL_MAX})) begin
            return WHEEL_MAX;
        end else if (sum < $signed({WHEEL_MIN[WHEEL_W-1], WHEEL_MIN})) begin
            return WHEEL_MIN;
        end
        return sum[WHEEL_W-1:0];
    endfunction

    // Something new to report since the last one
    assign w_pending = (r_acc_x != '0) || (r_acc_y != '0) || (r_acc_wheel != '0)
                    || (r_buttons_now != r_buttons_sent);

    // Report fields come straight from the current state
    assign o_rpt.button_bits = r_buttons_now;
    assign o_rpt.sum_x       = r_acc_x;
    assign o_rpt.sum_y       = r_acc_y;
    assign o_rpt.sum_wheel   = r_acc_wheel;

    // Next state for the accepted action
    always_comb begin
        n_buttons_now  = r_buttons_now;
        n_buttons_sent = r_buttons_sent;
        n_acc_x        = r_acc_x;
        n_acc_y        = r_acc_y;
        n_acc_wheel    = r_acc_wheel;
        o_rpt_valid    = 1'b0;
        if (i_fire) begin
            case (i_action)
                ACT_MOVE: begin
                    n_acc_x = sat_xy(r_acc_x, i_item.step_x);
                    n_acc_y = sat_xy(r_acc_y, i_item.step_y);
                end
                ACT_WHEEL: begin
                    n_acc_wheel = sat_wheel(r_acc_wheel, i_item.wheel_step);
                end
                ACT_BUTTON: begin
                    if (i_item.button_index <= BTN_LAST) begin
                        n_buttons_now[i_item.button_index] = i_item.pressed;
                    end
                end
                ACT_POLL: begin
                    if (w_pending) begin
                        o_rpt_valid    = 1'b1;
                        n_buttons_sent = r_buttons_now;
                        n_acc_x        = '0;
                        n_acc_y        = '0;
                        n_acc_wheel    = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons_now  <= '0;
            r_buttons_sent <= '0;
            r_acc_x        <= '0;
            r_acc_y        <= '0;
            r_acc_wheel    <= '0;
        end else begin
            r_buttons_now  <= n_buttons_now;
            r_buttons_sent <= n_buttons_sent;
            r_acc_x        <= n_acc_x;
            r_acc_y        <= n_acc_y;
            r_acc_wheel    <= n_acc_wheel;
        end
    end

    `ASSERT_NEVER(a_x_in_range, i_clk, i_rst_n, r_acc_x < XY_MIN)
    `ASSERT_NEVER(a_wheel_in_range, i_clk, i_rst_n, r_acc_wheel < WHEEL_MIN)
    `ASSERT_PROP(a_clear_after_report, i_clk, i_rst_n, o_rpt_valid |=> !w_pending)
    `ASSERT_PROP(a_report_only_on_poll, i_clk, i_rst_n, o_rpt_valid |-> (i_fire && w_pending))

endmodule

`default_nettype wire

>>> src/hmra_skid.sv
// Two-entry output buffer for reports: a main register and a skid register.
// Depends on hmra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hmra_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  hmra_pkg::t_report       i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output hmra_pkg::t_report       o_data
);
    import hmra_pkg::*;

    logic    r_m_valid, n_m_valid;
    logic    r_s_valid, n_s_valid;
    t_report r_m_data, n_m_data;
    t_report r_s_data, n_s_data;

    // Upstream may push while the skid entry is empty
    assign o_ready = !r_s_valid;
    assign o_valid = r_m_valid;
    assign o_data  = r_m_data;

    // Refill main from skid or input, or park input in skid on a stall
    always_comb begin
        n_m_valid = r_m_valid;
        n_s_valid = r_s_valid;
        n_m_data  = r_m_data;
        n_s_data  = r_s_data;
        if (!r_m_valid || i_ready) begin
            if (r_s_valid) begin
                n_m_valid = 1'b1;
                n_m_data  = r_s_data;
                n_s_valid = 1'b0;
            end else begin
                n_m_valid = i_valid;
                n_m_data  = i_data;
            end
        end else if (i_valid && !r_s_valid) begin
            n_s_valid = 1'b1;
            n_s_data  = i_data;
        end
    end

    // Hold valid flags under reset; data registers need none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            r_s_valid <= n_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_s_data <= n_s_data;
    end

    `ASSERT_PROP(a_skid_implies_main, i_clk, i_rst_n, r_s_valid |-> r_m_valid)
    `ASSERT_PROP(a_park_on_stall, i_clk, i_rst_n, (i_valid && o_ready && r_m_valid && !i_ready) |=> r_s_valid)
    `ASSERT_PROP(a_skid_drains, i_clk, i_rst_n, (r_s_valid && i_ready) |=> (r_m_valid && !r_s_valid))

endmodule

`default_nettype wire

>>> src/hid_mouse_report_accumulator.sv
// Top level of the HID relative-mouse report accumulator.
// Depends on hmra_pkg, hmra_core and hmra_skid.
//
// Channel | Direction | Ports          | Contents
// --------+-----------+----------------+------------------------------------------
// actions | in        | s_axis_*       | tuser: action; tdata: step_x, step_y,
//         |           |                |   wheel_step, button_index, pressed
// reports | out       | m_axis_*       | tdata: button_bits, sum_x, sum_y, sum_wheel
//
// One action is taken every clock while s_axis_tready is high; the saturating adds
// and the report check settle in the cycle the action is accepted.
// A report is registered in the output buffer, parked in the skid entry on a stall.
// Reset (synchronous, active low) zeroes the sums and both button sets.
// A two-entry output buffer absorbs stalls; s_axis_tready drops only while
// both entries hold reports.
`timescale 1ns / 1ps
`default_nettype none

module hid_mouse_report_accumulator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [15:0] step_x, [31:16] step_y, [39:32] wheel_step,
    // [42:40] button_index, [43] pressed, [47:44] zero
    input  wire logic [hmra_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] action
    input  wire logic [hmra_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [4:0] button_bits, [20:5] sum_x, [36:21] sum_y, [44:37] sum_wheel, [47:45] zero
    output logic [hmra_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);
    import hmra_pkg::*;

    localparam int unsigned ITEM_W = $bits(t_action_in);
    localparam int unsigned RPT_W  = $bits(t_report);

    logic       w_fire;
    logic       w_rpt_valid;
    t_action    w_action;
    t_action_in w_item;
    t_report    w_rpt;
    t_report    w_out;

    // Unpack the action transaction
    assign w_fire   = s_axis_tvalid && s_axis_tready;
    assign w_action = t_action'(s_axis_tuser);
    assign w_item   = t_action_in'(s_axis_tdata[ITEM_W-1:0]);

    hmra_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_action    (w_action),
        .i_item      (w_item),
        .o_rpt_valid (w_rpt_valid),
        .o_rpt       (w_rpt)
    );

    hmra_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rpt_valid),
        .o_ready (s_axis_tready),
        .i_data  (w_rpt),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    // Pack the report with zero fill
    assign m_axis_tdata = {{(OUT_TDATA_W-RPT_W){1'b0}}, w_out};

endmodule

`default_nettype wire
